/* rtl/core/dmnc_pkg.sv */
// ----------------------------------------------------------------------------
// dmnc_pkg
// Shared types, constants and register codes of the dual microphone noise
// classifier.
// ----------------------------------------------------------------------------
package dmnc_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int SUM_W       = 16;
  localparam int DIVIDEND_W  = SUM_W + 1;
  localparam int LEN_W       = 9;
  localparam int MATCH_W     = 9;
  localparam int HOLD_W      = 17;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // register index codes (paddr[4:2])
  localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd0;
  localparam logic [2:0] REG_LEVEL_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_MATCH_TOLERANCE  = 3'd2;
  localparam logic [2:0] REG_NOISE_ON_COUNT   = 3'd3;
  localparam logic [2:0] REG_NOISE_HOLD_COUNT = 3'd4;

  localparam logic [7:0]  RST_WINDOW_LENGTH    = 8'd1;
  localparam logic [7:0]  RST_LEVEL_THRESHOLD  = 8'd85;
  localparam logic [7:0]  RST_MATCH_TOLERANCE  = 8'd10;
  localparam logic [7:0]  RST_NOISE_ON_COUNT   = 8'd5;
  localparam logic [15:0] RST_NOISE_HOLD_COUNT = 16'd1000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] level_local;
    logic [SAMPLE_BITS-1:0] level_remote;
  } in_t;

  typedef struct packed {
    logic [7:0] mean_local;
    logic [7:0] mean_remote;
    logic       window_active;
    logic       noise_flag;
    logic       lamp_green;
    logic       lamp_red;
  } out_t;

  // request to the shared divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [LEN_W-1:0]      divisor;
  } div_req_t;

endpackage

/* rtl/core/dmnc_div.sv */
// ----------------------------------------------------------------------------
// dmnc_div
// Restoring divider, one quotient bit per cycle, quotient clamped to 255.
// ----------------------------------------------------------------------------
module dmnc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dmnc_pkg::div_req_t  req,
  output logic                done,
  output logic [7:0]          quotient
);

  logic [dmnc_pkg::LEN_W-1:0]  rem_r, rem_nxt;
  logic [7:0]                  quo_r, quo_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [dmnc_pkg::LEN_W-1:0]  divisor_r, divisor_nxt;
  logic [dmnc_pkg::LEN_W:0]    trial;
  logic                        fits;

  assign trial    = {rem_r, quo_r[7]};
  assign fits     = trial >= {1'b0, divisor_r};
  assign done     = busy_r && (cnt_r == 4'd0);
  assign quotient = quo_r;

  always_comb begin
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      divisor_nxt = req.divisor;
      if (req.dividend >= {req.divisor, 8'd0}) begin
        quo_nxt = 8'hff;
        cnt_nxt = 4'd0;
      end else begin
        rem_nxt = req.dividend[dmnc_pkg::DIVIDEND_W-1:8];
        quo_nxt = req.dividend[7:0];
        cnt_nxt = 4'd8;
      end
    end else if (busy_r) begin
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = fits ? trial[dmnc_pkg::LEN_W-1:0] - divisor_r : trial[dmnc_pkg::LEN_W-1:0];
        quo_nxt = {quo_r[6:0], fits};
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

endmodule

/* rtl/core/dual_mic_noise_classifier.sv */
// ----------------------------------------------------------------------------
// dual_mic_noise_classifier
// Windowed averaging of two microphone levels and noise/voice classification.
// ----------------------------------------------------------------------------
// After a sample pair that does not close a window, the block passes through
// S_ACC before it takes the next one. A closing sample holds off new samples
// while both window averages go through one shared divider that produces one
// quotient bit per cycle, local channel first, then remote (an average that
// clamps at 255 skips the bit steps), followed by classification in S_EVAL.
// A finished result sits in the output register while the next samples are
// taken; a second window end waits for it to be transferred.
module dual_mic_noise_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dmnc_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dmnc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmnc_pkg::ADDR_W-1:0]   paddr,
  input  logic [dmnc_pkg::DATA_W-1:0]   pwdata,
  output logic [dmnc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ACC     = 3'd1;
  localparam logic [2:0] S_DA_GO   = 3'd2;
  localparam logic [2:0] S_DA_WAIT = 3'd3;
  localparam logic [2:0] S_DB_GO   = 3'd4;
  localparam logic [2:0] S_DB_WAIT = 3'd5;
  localparam logic [2:0] S_EVAL    = 3'd6;

  // config registers
  logic [7:0]  win_len_r, thresh_r, tol_r, on_cnt_r;
  logic [15:0] hold_lim_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // state
  logic [2:0]                    state_r, state_nxt;
  logic [dmnc_pkg::SUM_W-1:0]    sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic [7:0]                    smp_cnt_r, smp_cnt_nxt;
  logic [dmnc_pkg::MATCH_W-1:0]  match_r, match_nxt;
  logic [dmnc_pkg::HOLD_W-1:0]   hold_r, hold_nxt;
  logic                          noise_r, noise_nxt;
  logic                          green_r, green_nxt;
  logic                          red_r, red_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dmnc_pkg::out_t                out_data_r, out_data_nxt;
  dmnc_pkg::in_t                 smp_r;
  logic [7:0]                    mean_a_r, mean_a_nxt, mean_b_r, mean_b_nxt;

  // datapath
  logic [dmnc_pkg::SUM_W:0]      add_a, add_b;
  logic [7:0]                    cnt_inc;
  logic [dmnc_pkg::LEN_W-1:0]    len;
  dmnc_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [7:0]                    div_q;
  logic                          active;
  logic [7:0]                    diff;
  logic [dmnc_pkg::MATCH_W-1:0]  match_inc;
  logic                          out_free;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      dmnc_pkg::REG_WINDOW_LENGTH:    prdata = {24'd0, win_len_r};
      dmnc_pkg::REG_LEVEL_THRESHOLD:  prdata = {24'd0, thresh_r};
      dmnc_pkg::REG_MATCH_TOLERANCE:  prdata = {24'd0, tol_r};
      dmnc_pkg::REG_NOISE_ON_COUNT:   prdata = {24'd0, on_cnt_r};
      dmnc_pkg::REG_NOISE_HOLD_COUNT: prdata = {16'd0, hold_lim_r};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= dmnc_pkg::RST_WINDOW_LENGTH;
      thresh_r   <= dmnc_pkg::RST_LEVEL_THRESHOLD;
      tol_r      <= dmnc_pkg::RST_MATCH_TOLERANCE;
      on_cnt_r   <= dmnc_pkg::RST_NOISE_ON_COUNT;
      hold_lim_r <= dmnc_pkg::RST_NOISE_HOLD_COUNT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dmnc_pkg::REG_WINDOW_LENGTH:    win_len_r  <= pwdata[7:0];
        dmnc_pkg::REG_LEVEL_THRESHOLD:  thresh_r   <= pwdata[7:0];
        dmnc_pkg::REG_MATCH_TOLERANCE:  tol_r      <= pwdata[7:0];
        dmnc_pkg::REG_NOISE_ON_COUNT:   on_cnt_r   <= pwdata[7:0];
        dmnc_pkg::REG_NOISE_HOLD_COUNT: hold_lim_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // shared divider
  assign len = (win_len_r == 8'd0) ? 9'd256 : {1'b0, win_len_r};

  always_comb begin
    div_req.start    = (state_r == S_DA_GO) || (state_r == S_DB_GO);
    div_req.divisor  = len;
    div_req.dividend = (state_r == S_DB_GO) ? {1'b0, sum_b_r} : {1'b0, sum_a_r};
    div_req.dividend = div_req.dividend + {9'd0, len[8:1]};
  end

  dmnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // accumulate and classify
  assign add_a     = {1'b0, sum_a_r} + {9'd0, smp_r.level_local};
  assign add_b     = {1'b0, sum_b_r} + {9'd0, smp_r.level_remote};
  assign cnt_inc   = smp_cnt_r + 8'd1;
  assign active    = (mean_a_r < thresh_r) || (mean_b_r < thresh_r);
  assign diff      = (mean_a_r > mean_b_r) ? mean_a_r - mean_b_r : mean_b_r - mean_a_r;
  assign match_inc = match_r + 9'd1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    smp_cnt_nxt   = smp_cnt_r;
    match_nxt     = match_r;
    hold_nxt      = hold_r;
    noise_nxt     = noise_r;
    green_nxt     = green_r;
    red_nxt       = red_r;
    mean_a_nxt    = mean_a_r;
    mean_b_nxt    = mean_b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_a_nxt = add_a[dmnc_pkg::SUM_W] ? dmnc_pkg::SUM_MAX : add_a[dmnc_pkg::SUM_W-1:0];
        sum_b_nxt = add_b[dmnc_pkg::SUM_W] ? dmnc_pkg::SUM_MAX : add_b[dmnc_pkg::SUM_W-1:0];
        if (noise_r && (hold_r != dmnc_pkg::HOLD_MAX)) hold_nxt = hold_r + 17'd1;
        if (cnt_inc == win_len_r) begin
          smp_cnt_nxt = 8'd0;
          state_nxt   = S_DA_GO;
        end else begin
          smp_cnt_nxt = cnt_inc;
          state_nxt   = S_IDLE;
        end
      end
      S_DA_GO:   state_nxt = S_DA_WAIT;
      S_DA_WAIT: begin
        if (div_done) begin
          mean_a_nxt = div_q;
          state_nxt  = S_DB_GO;
        end
      end
      S_DB_GO:   state_nxt = S_DB_WAIT;
      S_DB_WAIT: begin
        if (div_done) begin
          mean_b_nxt = div_q;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          if (active) begin
            if (diff < tol_r) begin
              match_nxt = match_inc;
              if (match_inc > {1'b0, on_cnt_r}) begin
                match_nxt = '0;
                hold_nxt  = '0;
                noise_nxt = 1'b1;
              end
            end else if (noise_r) begin
              if (hold_r > {1'b0, hold_lim_r}) begin
                hold_nxt  = '0;
                noise_nxt = 1'b0;
              end
            end else if (match_r != '0) begin
              match_nxt = match_r - 9'd1;
            end
            green_nxt = !noise_nxt;
            red_nxt   = noise_nxt;
          end else if (!noise_r) begin
            green_nxt = 1'b0;
            red_nxt   = 1'b0;
          end
          out_valid_nxt              = 1'b1;
          out_data_nxt.mean_local    = mean_a_r;
          out_data_nxt.mean_remote   = mean_b_r;
          out_data_nxt.window_active = active;
          out_data_nxt.noise_flag    = noise_nxt;
          out_data_nxt.lamp_green    = green_nxt;
          out_data_nxt.lamp_red      = red_nxt;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      smp_cnt_r   <= '0;
      match_r     <= '0;
      hold_r      <= '0;
      noise_r     <= 1'b0;
      green_r     <= 1'b0;
      red_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      smp_cnt_r   <= smp_cnt_nxt;
      match_r     <= match_nxt;
      hold_r      <= hold_nxt;
      noise_r     <= noise_nxt;
      green_r     <= green_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) smp_r <= in_data;
    mean_a_r   <= mean_a_nxt;
    mean_b_r   <= mean_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
